>>> rtl/core/lruk_pkg.sv
// ----------------------------------------------------------------------------
// LRU-K replacer package
// Sizes, register indexes, operation and status codes, and the structs that
// pass between the sequencer and the ranking unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lruk_pkg;

    // Frame store and history sizes.
    localparam int FRAME_COUNT = 16;
    localparam int MAX_K      = 8;
    localparam int STAMP_BITS = 32;

    // Field widths fixed by the interface.
    localparam int FRAME_W  = 4;
    localparam int TOTAL_W  = 5;
    localparam int FIU_W    = 5;
    localparam int DEPTH_W  = 4;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;

    // Derived widths.
    localparam int KCNT_W    = $clog2(MAX_K + 1);
    localparam int SLOT_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int SUM_W     = SLOT_W + 2;
    localparam int STORE_DEPTH = FRAME_COUNT * MAX_K;
    localparam int ADDR_W    = $clog2(STORE_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH = 2'd1;

    // Operation codes.
    localparam logic [1:0] OP_ACCESS   = 2'd0;
    localparam logic [1:0] OP_SET_EVICT = 2'd1;
    localparam logic [1:0] OP_EVICT    = 2'd2;
    localparam logic [1:0] OP_REMOVE   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_PINNED    = 2'd3;

    // One frame offered to the ranking unit.
    typedef struct packed {
        logic               valid;
        logic               inf;
        logic               empty;
        logic [FRAME_W-1:0] idx;
    } cand_t;

    // Outcome of a scan.
    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] idx;
    } best_t;

endpackage

`default_nettype wire

>>> rtl/core/lruk_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lruk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/lruk_rank.sv
// ----------------------------------------------------------------------------
// LRU-K ranking unit
// Computes one candidate's age per cycle and keeps the best frame so far.
// ----------------------------------------------------------------------------
`default_nettype none

module lruk_rank (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              clear,
    input  wire lruk_pkg::cand_t                   cand,
    input  wire logic [lruk_pkg::STAMP_BITS-1:0]   stamp,
    input  wire logic [lruk_pkg::STAMP_BITS-1:0]   now,
    output lruk_pkg::best_t                        best
);
    import lruk_pkg::*;

    logic                  found_reg, found_next;
    logic                  inf_reg, inf_next;
    logic                  empty_reg, empty_next;
    logic [STAMP_BITS-1:0] age_reg, age_next;
    logic [FRAME_W-1:0]    idx_reg, idx_next;
    logic [STAMP_BITS-1:0] age;
    logic                  adopt;

    // Age of the candidate, wrapping with the counter width.
    assign age = cand.empty ? '0 : (now - stamp);

    // Ranking: infinite beats finite, empty beats other infinite, then age.
    always_comb
    begin
        if (!found_reg)
        begin
            adopt = 1'b1;
        end
        else if (cand.inf != inf_reg)
        begin
            adopt = cand.inf;
        end
        else if (cand.inf && (cand.empty != empty_reg))
        begin
            adopt = cand.empty;
        end
        else if (cand.inf && cand.empty)
        begin
            adopt = 1'b0;
        end
        else
        begin
            adopt = age > age_reg;
        end
    end

    // Next best frame.
    always_comb
    begin
        found_next = found_reg;
        inf_next   = inf_reg;
        empty_next = empty_reg;
        age_next   = age_reg;
        idx_next   = idx_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (cand.valid && adopt)
        begin
            found_next = 1'b1;
            inf_next   = cand.inf;
            empty_next = cand.empty;
            age_next   = age;
            idx_next   = cand.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inf_reg   <= inf_next;
        empty_reg <= empty_next;
        age_reg   <= age_next;
        idx_reg   <= idx_next;
    end

    assign best.found = found_reg;
    assign best.idx   = idx_reg;

endmodule

`default_nettype wire

>>> rtl/core/lru_k_frame_replacer_top.sv
// ----------------------------------------------------------------------------
// LRU-K frame replacer
// Tracks access history per frame and picks eviction victims by LRU-K.
//
//   Channel   Signals                                        Handshake
//   command   start, opcode, frame_index, make_evictable     start & !busy
//   result    done, status, victim_frame, evictable_total    done, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data      valid & ready
//
// Access, set-evictable and remove go from accept through S_EXEC to a registered result.
// Evict runs S_SCAN, S_DRAIN and S_FINISH: the scan reads one frame's stamp per
// cycle from the single history RAM read port and ranks it in one shared
// subtract and compare unit, then drains and commits. busy is high meanwhile.
// Reset clears frame state and resets control state, but not the latched command; the stamp RAM is not cleared.
// The result beat is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_k_frame_replacer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       opcode,
    input  wire logic [lruk_pkg::FRAME_W-1:0]     frame_index,
    input  wire logic                             make_evictable,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic [lruk_pkg::FRAME_W-1:0]          victim_frame,
    output logic [lruk_pkg::TOTAL_W-1:0]          evictable_total,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lruk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lruk_pkg::CFG_W-1:0]       cfg_data
);
    import lruk_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [FIU_W-1:0]   fiu_reg, fiu_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;

    // Latched command.
    logic [1:0]         op_reg, op_next;
    logic [FRAME_W-1:0] idx_reg, idx_next;
    logic               mark_reg, mark_next;

    // Frame state.
    logic [FRAME_COUNT-1:0] present_reg, present_next;
    logic [FRAME_COUNT-1:0] evict_reg, evict_next;
    logic [KCNT_W-1:0]     count_reg [FRAME_COUNT];
    logic [KCNT_W-1:0]     count_next [FRAME_COUNT];
    logic [SLOT_W-1:0]     head_reg [FRAME_COUNT];
    logic [SLOT_W-1:0]     head_next [FRAME_COUNT];
    logic [STAMP_BITS-1:0] clock_reg, clock_next;
    logic [TOTAL_W-1:0]    tally_reg, tally_next;

    // Scan control.
    logic [FRAME_W-1:0] scan_reg, scan_next;
    cand_t              cand_reg, cand_next;

    // Result registers.
    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic [FRAME_W-1:0] victim_reg, victim_next;

    // Shared signals.
    logic [FRAME_W-1:0]    cur;
    logic [KCNT_W-1:0]     k;
    logic                  in_range;
    logic [KCNT_W-1:0]     cur_count;
    logic [SLOT_W-1:0]     cur_head;
    logic                  cur_empty;
    logic                  cur_inf;
    logic [KCNT_W-1:0]     back;
    logic [SUM_W-1:0]      slot_sum;
    logic [SLOT_W-1:0]     rd_slot;
    logic [SLOT_W-1:0]     head_inc;
    logic [KCNT_W:0]       count_inc;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  wr_en;
    logic [STAMP_BITS-1:0] rd_data;
    logic                  rank_clear;
    best_t                 best;

    // Effective K: zero acts as one, large values saturate.
    always_comb
    begin
        if (depth_reg == '0)
        begin
            k = KCNT_W'(1);
        end
        else if (KCNT_W'(depth_reg) > KCNT_W'(MAX_K))
        begin
            k = KCNT_W'(MAX_K);
        end
        else
        begin
            k = KCNT_W'(depth_reg);
        end
    end

    assign in_range = {1'b0, idx_reg} < fiu_reg;

    // One frame is looked at per cycle: the scan frame or the command frame.
    assign cur       = (state_reg == S_SCAN) ? scan_reg : idx_reg;
    assign cur_count = count_reg[cur];
    assign cur_head  = head_reg[cur];
    assign cur_empty = cur_count == '0;
    assign cur_inf   = cur_count < k;
    assign back      = cur_inf ? cur_count : k;

    // Ring slot of the stamp written the chosen number of accesses ago.
    assign slot_sum = SUM_W'(cur_head) + SUM_W'(MAX_K) - SUM_W'(back);
    assign rd_slot  = (slot_sum >= SUM_W'(MAX_K)) ? SLOT_W'(slot_sum - SUM_W'(MAX_K))
                                                  : SLOT_W'(slot_sum);
    assign head_inc = (SUM_W'(cur_head) + SUM_W'(1) == SUM_W'(MAX_K)) ? '0
                                                                     : cur_head + 1'b1;
    assign count_inc = {1'b0, cur_count} + 1'b1;

    assign rd_addr = ADDR_W'(cur) * ADDR_W'(MAX_K) + ADDR_W'(rd_slot);
    assign wr_addr = ADDR_W'(cur) * ADDR_W'(MAX_K) + ADDR_W'(cur_head);
    assign wr_en   = (state_reg == S_EXEC) && (op_reg == OP_ACCESS) && in_range;

    // Sequencer and frame state update.
    always_comb
    begin
        state_next   = state_reg;
        fiu_next     = fiu_reg;
        depth_next   = depth_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        mark_next    = mark_reg;
        present_next = present_reg;
        evict_next   = evict_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        clock_next   = clock_reg;
        tally_next   = tally_reg;
        scan_next    = scan_reg;
        cand_next    = '0;
        done_next    = 1'b0;
        status_next  = status_reg;
        victim_next  = victim_reg;
        rank_clear   = 1'b0;

        // Configuration beat.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAMES_IN_USE: fiu_next   = FIU_W'(cfg_data);
                REG_HISTORY_DEPTH: depth_next = DEPTH_W'(cfg_data);
                default:           ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = opcode;
                    idx_next  = frame_index;
                    mark_next = make_evictable;
                    if (opcode == OP_EVICT)
                    begin
                        scan_next  = '0;
                        rank_clear = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                status_next = ST_OK;
                victim_next = '0;
                if (!in_range)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    case (op_reg)
                        OP_ACCESS:
                        begin
                            head_next[cur]  = head_inc;
                            count_next[cur] = (count_inc > (KCNT_W + 1)'(k)) ? k
                                                                : KCNT_W'(count_inc);
                            present_next[cur] = 1'b1;
                            clock_next = clock_reg + 1'b1;
                        end
                        OP_SET_EVICT:
                        begin
                            present_next[cur] = 1'b1;
                            if (evict_reg[cur] != mark_reg)
                            begin
                                tally_next = mark_reg ? tally_reg + 1'b1 : tally_reg - 1'b1;
                            end
                            evict_next[cur] = mark_reg;
                        end
                        default:
                        begin
                            if (present_reg[cur])
                            begin
                                if (!evict_reg[cur])
                                begin
                                    status_next = ST_PINNED;
                                end
                                else
                                begin
                                    present_next[cur] = 1'b0;
                                    evict_next[cur]   = 1'b0;
                                    count_next[cur]   = '0;
                                    head_next[cur]    = '0;
                                    tally_next        = tally_reg - 1'b1;
                                end
                            end
                        end
                    endcase
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                cand_next.valid = present_reg[cur] && evict_reg[cur];
                cand_next.inf   = cur_inf;
                cand_next.empty = cur_empty;
                cand_next.idx   = cur;
                scan_next       = scan_reg + 1'b1;
                if (scan_reg == FRAME_W'(FRAME_COUNT - 1))
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!best.found)
                begin
                    status_next = ST_NONE;
                    victim_next = '0;
                end
                else
                begin
                    status_next             = ST_OK;
                    victim_next             = best.idx;
                    present_next[best.idx]  = 1'b0;
                    evict_next[best.idx]    = 1'b0;
                    count_next[best.idx]    = '0;
                    head_next[best.idx]     = '0;
                    tally_next              = tally_reg - 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, frame state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fiu_reg     <= FIU_W'(16);
            depth_reg   <= DEPTH_W'(2);
            present_reg <= '0;
            evict_reg   <= '0;
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
            clock_reg   <= '0;
            tally_reg   <= '0;
            scan_reg    <= '0;
            cand_reg    <= '0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            victim_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fiu_reg     <= fiu_next;
            depth_reg   <= depth_next;
            present_reg <= present_next;
            evict_reg   <= evict_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            clock_reg   <= clock_next;
            tally_reg   <= tally_next;
            scan_reg    <= scan_next;
            cand_reg    <= cand_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            victim_reg  <= victim_next;
        end
    end

    // Command payload needs no reset.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        idx_reg  <= idx_next;
        mark_reg <= mark_next;
    end

    // History stamp store.
    lruk_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_stamps (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (clock_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared age compare unit.
    lruk_rank u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (rank_clear),
        .cand  (cand_reg),
        .stamp (rd_data),
        .now   (clock_reg),
        .best  (best)
    );

    assign busy            = state_reg != S_IDLE;
    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign status          = status_reg;
    assign victim_frame    = victim_reg;
    assign evictable_total = tally_reg;

endmodule

`default_nettype wire
